FILE: rtl/dsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set union package
// Field widths, operation codes and the control and status bundles between
// sequencer and datapath.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int ELEM_W   = 7;
  localparam int SIZE_W   = 8;
  localparam int ELEM_MAX = (1 << ELEM_W) - 1;
  localparam int SIZE_MAX = (1 << SIZE_W) - 1;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_UNITE = 1'b1
  } op_t;

  // Decoded sequencer steps that drive the datapath.
  typedef struct packed {
    logic idle;
    logic clear_wr;
    logic accept;
    logic find_rd;
    logic find_cmp;
    logic comp_rd;
    logic comp_wr;
    logic size_rd_a;
    logic size_rd_b;
    logic finish;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic eq;
    logic phase;
    logic clr_last;
  } stat_t;

endpackage

FILE: rtl/disjoint_set_union_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set union engine
// Union-find over MAX_ELEMENTS elements with full path compression and
// union by pointing the first root at the second.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+------------------
//  request  | operation, first_element, second_element       | start & !busy
//  result   | first_root, second_root, same_set, merged,     | done, one cycle
//           | set_size                                       |
//
// A request keeps the engine busy until its result strobe, and every step of
// the root walks goes through the single read port of the parent memory.
// After reset a clearing pass loads both tables while busy stays high. The
// result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module disjoint_set_union_engine #(
  parameter int MAX_ELEMENTS = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic [dsu_pkg::ELEM_W-1:0] first_element,
  input  logic [dsu_pkg::ELEM_W-1:0] second_element,
  output logic                       done,
  output logic [dsu_pkg::ELEM_W-1:0] first_root,
  output logic [dsu_pkg::ELEM_W-1:0] second_root,
  output logic                       same_set,
  output logic                       merged,
  output logic [dsu_pkg::SIZE_W-1:0] set_size
);
  import dsu_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);

  ctrl_t ctl;
  stat_t stat;

  logic             op_q;
  logic [IDX_W-1:0] a_q;
  logic [IDX_W-1:0] b_q;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] ra;
  logic [IDX_W-1:0] rb;
  logic             phase;
  logic             same_q;
  logic [SIZE_W-1:0] size_a;
  logic [IDX_W-1:0] clr;

  logic [IDX_W-1:0]  prd;
  logic [SIZE_W-1:0] srd;
  logic [IDX_W-1:0]  root_v;
  logic [IDX_W-1:0]  cmp_y;
  logic              eq;
  logic              merge;
  logic [SIZE_W:0]   sum_raw;
  logic [SIZE_W-1:0] sum;

  logic              p_we;
  logic [IDX_W-1:0]  p_waddr;
  logic [IDX_W-1:0]  p_wdata;
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr;
  logic [SIZE_W-1:0] s_wdata;
  logic [IDX_W-1:0]  s_raddr;

  // Reduces an element index modulo MAX_ELEMENTS by restoring subtraction.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [ELEM_W-1:0] v);
    logic [ELEM_W-1:0] r;
    r = v;
    for (int k = ELEM_W - 1; k >= 0; k--) begin
      if ((MAX_ELEMENTS << k) <= ELEM_MAX) begin
        if (r >= ELEM_W'(MAX_ELEMENTS << k)) begin
          r = r - ELEM_W'(MAX_ELEMENTS << k);
        end
      end
    end
    return IDX_W'(r);
  endfunction

  dsu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl)
  );

  dsu_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (cur),
    .rdata (prd)
  );

  dsu_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_ELEMENTS)) u_size (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (srd)
  );

  // The one comparator: parent link against the node during a walk, node
  // against its root during compression, and the two roots before the update.
  assign root_v = phase ? rb : ra;
  always_comb begin
    if (ctl.find_cmp) begin
      cmp_y = prd;
    end else if (ctl.size_rd_a) begin
      cmp_y = ra;
    end else begin
      cmp_y = root_v;
    end
  end
  assign eq = (cur == cmp_y);

  assign stat.eq       = eq;
  assign stat.phase    = phase;
  assign stat.clr_last = (clr == IDX_W'(MAX_ELEMENTS - 1));

  assign merge   = (op_q == OP_UNITE) & ~same_q;
  assign sum_raw = {1'b0, size_a} + {1'b0, srd};
  assign sum     = sum_raw[SIZE_W] ? SIZE_W'(SIZE_MAX) : sum_raw[SIZE_W-1:0];

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur;
    p_wdata = root_v;
    if (ctl.clear_wr) begin
      p_we    = 1'b1;
      p_waddr = clr;
      p_wdata = clr;
    end else if (ctl.comp_wr) begin
      p_we = 1'b1;
    end else if (ctl.finish && merge) begin
      p_we    = 1'b1;
      p_waddr = ra;
      p_wdata = rb;
    end
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = rb;
    s_wdata = sum;
    if (ctl.clear_wr) begin
      s_we    = 1'b1;
      s_waddr = clr;
      s_wdata = SIZE_W'(1);
    end else if (ctl.finish && merge) begin
      s_we = 1'b1;
    end
  end

  assign s_raddr = ctl.size_rd_a ? ra : rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      done <= 1'b0;
    end else begin
      if (ctl.clear_wr) begin
        clr <= clr + IDX_W'(1);
      end
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_q  <= operation;
      a_q   <= wrap_idx(first_element);
      b_q   <= wrap_idx(second_element);
      cur   <= wrap_idx(first_element);
      phase <= 1'b0;
    end
    if (ctl.find_cmp) begin
      if (eq) begin
        if (phase) begin
          rb <= cur;
        end else begin
          ra <= cur;
        end
        cur <= phase ? b_q : a_q;
      end else begin
        cur <= prd;
      end
    end
    if (ctl.comp_rd && eq && !phase) begin
      phase <= 1'b1;
      cur   <= b_q;
    end
    if (ctl.comp_wr) begin
      cur <= prd;
    end
    if (ctl.size_rd_a) begin
      same_q <= eq;
    end
    if (ctl.size_rd_b) begin
      size_a <= srd;
    end
    if (ctl.finish) begin
      first_root  <= ELEM_W'(ra);
      second_root <= ELEM_W'(rb);
      same_set    <= same_q;
      merged      <= merge;
      set_size    <= merge ? sum : size_a;
    end
  end

  assign busy = ~ctl.idle;

endmodule

FILE: rtl/dsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set union sequencer
// Steps the clearing pass, both root walks with path compression, the size
// lookups and the final update.
// ----------------------------------------------------------------------------
module dsu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dsu_pkg::stat_t stat,
  output dsu_pkg::ctrl_t ctl
);
  import dsu_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_FRD   = 10'b0000000100,
    S_FCMP  = 10'b0000001000,
    S_CRD   = 10'b0000010000,
    S_CWR   = 10'b0000100000,
    S_SRA   = 10'b0001000000,
    S_SRB   = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_FRD;
      S_FRD:   state_next = S_FCMP;
      S_FCMP:  state_next = stat.eq ? S_CRD : S_FRD;
      S_CRD: begin
        if (!stat.eq) begin
          state_next = S_CWR;
        end else begin
          // This element's path is compressed: the second walk or the size reads follow.
          state_next = stat.phase ? S_SRA : S_FRD;
        end
      end
      S_CWR:   state_next = S_CRD;
      S_SRA:   state_next = S_SRB;
      S_SRB:   state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.idle      = (state == S_IDLE);
    ctl.clear_wr  = (state == S_CLEAR);
    ctl.accept    = (state == S_IDLE) && start;
    ctl.find_rd   = (state == S_FRD);
    ctl.find_cmp  = (state == S_FCMP);
    ctl.comp_rd   = (state == S_CRD);
    ctl.comp_wr   = (state == S_CWR);
    ctl.size_rd_a = (state == S_SRA);
    ctl.size_rd_b = (state == S_SRB);
    ctl.finish    = (state == S_FIN);
  end

endmodule

FILE: rtl/dsu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set union port checker
// Watches the top-level ports for request and result ordering.
// ----------------------------------------------------------------------------
module dsu_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       same_set,
  input logic                       merged,
  input logic [dsu_pkg::SIZE_W-1:0] set_size
);
  import dsu_pkg::*;

  // A result appears only once the engine is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request makes the engine busy and gives no result at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted without going busy");

  // Two consecutive result strobes would mean a request answered twice.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result repeated");

  a_merge_distinct: assert property (@(posedge clk) disable iff (rst)
    (done && merged) |-> !same_set)
    else $error("merge reported for one set");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (set_size != '0))
    else $error("empty set size reported");

endmodule

bind disjoint_set_union_engine dsu_chk u_dsu_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .same_set (same_set),
  .merged   (merged),
  .set_size (set_size)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set union engine testbench
// Drives query and unite requests through the start/busy handshake, tracks
// its own parent and size tables with path compression, and checks every
// result strobe against the predicted roots, flags and set size.
// ----------------------------------------------------------------------------
module testbench;
  import dsu_pkg::*;

  localparam int NUM_ELEMS   = ELEM_MAX + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int REPORT_MAX  = 10;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [SIZE_W-1:0] count_t;

  typedef struct packed {
    op_t   op;
    elem_t first;
    elem_t second;
  } request_t;

  typedef struct packed {
    elem_t  first_root;
    elem_t  second_root;
    logic   same_set;
    logic   merged;
    count_t set_size;
  } answer_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  logic   operation = 1'b0;
  elem_t  first_element = '0;
  elem_t  second_element = '0;
  logic   done;
  elem_t  first_root;
  elem_t  second_root;
  logic   same_set;
  logic   merged;
  count_t set_size;

  request_t request_queue[$];
  answer_t  awaited_answers[$];
  elem_t    link_tbl[NUM_ELEMS];
  count_t   count_tbl[NUM_ELEMS];
  logic     accepted = 1'b0;
  int       sender_idle_pct = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  disjoint_set_union_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .first_element  (first_element),
    .second_element (second_element),
    .done           (done),
    .first_root     (first_root),
    .second_root    (second_root),
    .same_set       (same_set),
    .merged         (merged),
    .set_size       (set_size)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Finds the root of a node and points every node on the walked path at it.
  function automatic elem_t root_of(elem_t origin);
    elem_t node;
    elem_t top;
    elem_t nxt;
    int    steps;
    node = origin;
    steps = 0;
    while (link_tbl[node] != node && steps < NUM_ELEMS) begin
      node = link_tbl[node];
      steps++;
    end
    top = node;
    node = origin;
    steps = 0;
    while (node != top && steps < NUM_ELEMS) begin
      nxt = link_tbl[node];
      link_tbl[node] = top;
      node = nxt;
      steps++;
    end
    return top;
  endfunction

  function automatic answer_t apply_union_request(op_t op, elem_t a, elem_t b);
    answer_t          ans;
    elem_t            ra;
    elem_t            rb;
    logic [SIZE_W:0]  total;
    ra = root_of(a);
    rb = root_of(b);
    ans.first_root  = ra;
    ans.second_root = rb;
    ans.same_set    = (ra == rb);
    ans.merged      = 1'b0;
    if (op == OP_UNITE && ra != rb) begin
      total = {1'b0, count_tbl[ra]} + {1'b0, count_tbl[rb]};
      if (total > SIZE_MAX) begin
        total = (SIZE_W + 1)'(SIZE_MAX);
      end
      link_tbl[ra]  = rb;
      count_tbl[rb] = total[SIZE_W-1:0];
      ans.merged    = 1'b1;
      ans.set_size  = count_tbl[rb];
    end else begin
      ans.set_size = count_tbl[ra];
    end
    return ans;
  endfunction

  // Result checking first, then prediction for a request taken at this edge.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    cycle_count <= cycle_count + 1;
    accepted <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        got = '{first_root, second_root, same_set, merged, set_size};
        if (awaited_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] unexpected result: roots %0d/%0d same %0b merged %0b size %0d",
                     $realtime, got.first_root, got.second_root, got.same_set,
                     got.merged, got.set_size);
          end
        end else begin
          want = awaited_answers.pop_front();
          if (got.first_root != want.first_root || got.second_root != want.second_root ||
              got.same_set != want.same_set || got.merged != want.merged ||
              got.set_size != want.set_size) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("[%0t] mismatch: expected roots %0d/%0d same %0b merged %0b size %0d",
                       $realtime, want.first_root, want.second_root, want.same_set,
                       want.merged, want.set_size);
              $display("[%0t]           actual   roots %0d/%0d same %0b merged %0b size %0d",
                       $realtime, got.first_root, got.second_root, got.same_set,
                       got.merged, got.set_size);
            end
          end
        end
      end
      if (start && !busy) begin
        awaited_answers = {awaited_answers,
                           apply_union_request(op_t'(operation), first_element,
                                               second_element)};
      end
    end
  end

  // Request driver: holds a request until it is taken, then maybe idles.
  always @(negedge clk) begin
    request_t req;
    if (!rst && (!start || accepted)) begin
      if (request_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        req = request_queue.pop_front();
        start          <= 1'b1;
        operation      <= req.op;
        first_element  <= req.first;
        second_element <= req.second;
      end else begin
        start          <= 1'b0;
        operation      <= 1'($urandom_range(0, 1));
        first_element  <= elem_t'($urandom_range(0, ELEM_MAX));
        second_element <= elem_t'($urandom_range(0, ELEM_MAX));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic queue_request(op_t op, int a, int b);
    request_t req;
    req.op     = op;
    req.first  = elem_t'(a);
    req.second = elem_t'(b);
    request_queue = {request_queue, req};
  endtask

  task automatic wait_for_drain();
    do begin
      @(posedge clk);
    end while (request_queue.size() != 0 || start || awaited_answers.size() != 0);
  endtask

  // Most picks stay inside a 32-element window so sets grow slowly and
  // parent chains get a chance to form before everything is merged.
  function automatic int pick_element(int base);
    if ($urandom_range(0, 9) != 0) begin
      return base + $urandom_range(0, 31);
    end
    return $urandom_range(0, ELEM_MAX);
  endfunction

  task automatic run_random_phase(int idle_pct, int count, int base);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      queue_request(($urandom_range(0, 99) < 40) ? OP_UNITE : OP_QUERY,
                    pick_element(base), pick_element(base));
    end
    wait_for_drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_ELEMS; i++) begin
      link_tbl[i]  = elem_t'(i);
      count_tbl[i] = count_t'(1);
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part: extremes, both operations, unite within one set, and a
    // long chain that the following query has to walk and compress.
    sender_idle_pct = 0;
    queue_request(OP_QUERY, 0, 0);
    queue_request(OP_QUERY, ELEM_MAX, ELEM_MAX);
    queue_request(OP_QUERY, 0, ELEM_MAX);
    queue_request(OP_UNITE, 9, 9);
    queue_request(OP_UNITE, 0, ELEM_MAX);
    queue_request(OP_UNITE, ELEM_MAX, 0);
    queue_request(OP_QUERY, ELEM_MAX, 0);
    for (int i = 1; i < 9; i++) begin
      queue_request(OP_UNITE, i, i + 1);
    end
    queue_request(OP_QUERY, 1, 0);
    queue_request(OP_QUERY, 2, 1);
    queue_request(OP_UNITE, 0, 5);
    queue_request(OP_UNITE, 3, ELEM_MAX);
    queue_request(OP_QUERY, 64, 9);
    wait_for_drain();

    run_random_phase(0, 290, 0);
    run_random_phase(50, 290, 32);
    run_random_phase(0, 290, 64);
    run_random_phase(14, 290, 96);

    // Join everything into one set so the largest size shows up.
    sender_idle_pct = 14;
    for (int i = 0; i < ELEM_MAX; i++) begin
      queue_request(OP_UNITE, i, i + 1);
    end
    queue_request(OP_QUERY, ELEM_MAX, 0);
    wait_for_drain();

    repeat (60) @(posedge clk);
    mismatch_count += awaited_answers.size();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dsu_pkg.sv
rtl/dsu_ram.sv
rtl/dsu_ctrl.sv
rtl/disjoint_set_union_engine.sv
rtl/dsu_chk.sv
tb/testbench.sv
